// ----- rtl/msh_pkg.sv -----
package msh_pkg;

	// seed start values
	localparam logic [31:0] SEED_ONE_START = 32'h7FED7FED;
	localparam logic [31:0] SEED_TWO_START = 32'hEEEEEEEE;

	// crypt table geometry
	localparam int NUM_HASH_TYPES = 5;
	localparam int ROM_ROWS       = 5;
	localparam int ROM_COLS       = 256;
	localparam int ROM_DEPTH      = ROM_ROWS * ROM_COLS;
	localparam int ROW_W          = 3;
	localparam int COL_W          = $clog2(ROM_COLS);
	localparam int ROM_AW         = $clog2(ROM_DEPTH);

	// table generator: s' = (s * 125 + 3) mod 0x2AAAAB
	localparam int              LCG_W    = 22;
	localparam logic [LCG_W-1:0] LCG_SEED = 22'h100001;
	localparam logic [LCG_W-1:0] LCG_MOD  = 22'h2AAAAB;
	localparam int              LCG_MUL  = 125;
	localparam int              LCG_XW   = 29;
	localparam int              LCG_PW   = 30;
	// 3 * LCG_MOD = 2^23 + 1, so (3x) >> 23 is the quotient or one above it
	localparam int              LCG_QSH  = 23;

	typedef enum logic [1:0] {
		FS_HI,
		FS_LO,
		FS_DONE
	} fill_state_t;

	typedef struct packed {
		logic              we;
		logic [ROM_AW-1:0] addr;
		logic [31:0]       data;
	} fill_wr_t;

	typedef struct packed {
		logic step;
		logic reload;
	} seed_ctl_t;

	function automatic logic [LCG_W-1:0] lcg_next(input logic [LCG_W-1:0] s);
		logic [LCG_XW-1:0]  x;
		logic [LCG_XW+1:0]  x3;
		logic [7:0]         q;
		logic [LCG_PW-1:0]  p;
		logic [LCG_PW-1:0]  r;
		x  = LCG_XW'(s) * LCG_XW'(LCG_MUL) + LCG_XW'(3);
		x3 = (LCG_XW+2)'(x) * (LCG_XW+2)'(3);
		q  = 8'(x3 >> LCG_QSH);
		p  = LCG_PW'(q) * LCG_PW'(LCG_MOD);
		r  = LCG_PW'(x) - p;
		if (LCG_PW'(x) < p) begin
			r = r + LCG_PW'(LCG_MOD);
		end
		return r[LCG_W-1:0];
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (c inside {[8'h61:8'h7A]}) begin
			u = c - 8'h20;
		end
		return u;
	endfunction

endpackage

// ----- rtl/msh_ram.sv -----
module msh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1280
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/msh_fill.sv -----
module msh_fill (
	input  logic              clk,
	input  logic              arst_n,
	output msh_pkg::fill_wr_t wr,
	output logic              busy
);

	msh_pkg::fill_state_t state_q, state_d;

	logic [msh_pkg::LCG_W-1:0] lcg_q;
	logic [msh_pkg::LCG_W-1:0] lcg_nxt;
	logic [15:0]               hi_q;
	logic [msh_pkg::ROW_W-1:0] row_q;
	logic [msh_pkg::COL_W-1:0] col_q;
	logic                      last;

	assign lcg_nxt = msh_pkg::lcg_next(lcg_q);
	assign last    = (row_q == msh_pkg::ROW_W'(msh_pkg::ROM_ROWS - 1)) &&
	                 (col_q == msh_pkg::COL_W'(msh_pkg::ROM_COLS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msh_pkg::FS_HI:   state_d = msh_pkg::FS_LO;
			msh_pkg::FS_LO:   state_d = last ? msh_pkg::FS_DONE : msh_pkg::FS_HI;
			msh_pkg::FS_DONE: state_d = msh_pkg::FS_DONE;
			default:          state_d = msh_pkg::FS_DONE;
		endcase
	end

	// outputs
	always_comb begin
		wr.we   = 1'b0;
		wr.addr = msh_pkg::ROM_AW'({row_q, col_q});
		wr.data = {hi_q, lcg_nxt[15:0]};
		busy    = 1'b1;
		case (state_q)
			msh_pkg::FS_HI:   wr.we = 1'b0;
			msh_pkg::FS_LO:   wr.we = 1'b1;
			msh_pkg::FS_DONE: busy  = 1'b0;
			default:          busy  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msh_pkg::FS_HI;
			lcg_q   <= msh_pkg::LCG_SEED;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != msh_pkg::FS_DONE) begin
				lcg_q <= lcg_nxt;
			end
			// rows inner, columns outer
			if (state_q == msh_pkg::FS_LO) begin
				if (row_q == msh_pkg::ROW_W'(msh_pkg::ROM_ROWS - 1)) begin
					row_q <= '0;
					col_q <= col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == msh_pkg::FS_HI) begin
			hi_q <= lcg_nxt[15:0];
		end
	end

endmodule

// ----- rtl/msh_seed.sv -----
module msh_seed (
	input  logic               clk,
	input  logic               arst_n,
	input  msh_pkg::seed_ctl_t ctl,
	input  logic [7:0]         char_up,
	input  logic [31:0]        word,
	output logic [31:0]        seed_one
);

	logic [31:0] seed_one_q;
	logic [31:0] seed_two_q;
	logic [31:0] one_nxt;
	logic [31:0] two_nxt;

	assign one_nxt  = word ^ (seed_one_q + seed_two_q);
	assign two_nxt  = 32'(char_up) + one_nxt + seed_two_q + (seed_two_q << 5) + 32'd3;
	assign seed_one = seed_one_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= msh_pkg::SEED_ONE_START;
			seed_two_q <= msh_pkg::SEED_TWO_START;
		end else if (ctl.reload) begin
			seed_one_q <= msh_pkg::SEED_ONE_START;
			seed_two_q <= msh_pkg::SEED_TWO_START;
		end else if (ctl.step) begin
			seed_one_q <= one_nxt;
			seed_two_q <= two_nxt;
		end
	end

endmodule

// ----- rtl/mpq_string_hash.sv -----
// Output: a hash is presented on out_valid once its terminating zero byte has left
//   the table read stage and the hash has been loaded into the result reg.
// Throughput: one byte per cycle after the table fill, set by the seed add/xor update;
//   a terminator waits in stage 1 only while a stalled hash still holds the result reg.
// Reset: arst_n clears control, loads the seed start values and hash_type = 0, then
//   the crypt table is generated into RAM with in_stall high throughout.
module mpq_string_hash (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	// hash results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data
);

	// ---------------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------------
	logic [msh_pkg::ROW_W-1:0] hash_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_type_q <= '0;
		end else if (cfg_wr_en) begin
			hash_type_q <= cfg_wr_data;
		end
	end

	// ---------------------------------------------------------------------
	// crypt table: generated into RAM after reset
	// ---------------------------------------------------------------------
	msh_pkg::fill_wr_t fill_wr;
	logic              fill_busy;

	msh_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fill_wr),
		.busy   (fill_busy)
	);

	// ---------------------------------------------------------------------
	// stage 1: byte folded to upper case, table word read in flight
	// ---------------------------------------------------------------------
	logic                       in_accept;
	logic [7:0]                 char_up;
	logic                       row_ok;
	logic [msh_pkg::ROM_AW-1:0] rd_addr;
	logic [31:0]                rom_word;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       zero_s1;
	logic       row_ok_s1;

	logic       advance_s1;
	logic       out_free;

	assign char_up = msh_pkg::to_upper(char_byte);
	// rows past the last hash type read as zero
	assign row_ok  = (hash_type_q < msh_pkg::ROW_W'(msh_pkg::NUM_HASH_TYPES));
	assign rd_addr = row_ok ? msh_pkg::ROM_AW'({hash_type_q, char_up}) : '0;

	// RAM read data holds while stage 1 is stalled (read only on accept)
	msh_ram #(
		.WIDTH (32),
		.DEPTH (msh_pkg::ROM_DEPTH)
	) u_rom (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_wr.addr),
		.wdata (fill_wr.data),
		.re    (in_accept),
		.raddr (rd_addr),
		.rdata (rom_word)
	);

	// output slot free this cycle: empty, or its transaction completes now
	assign out_free   = !out_valid || !out_stall;
	// nonzero bytes always retire; a terminator needs the output slot
	assign advance_s1 = valid_s1 && (!zero_s1 || out_free);
	assign in_stall   = fill_busy || (valid_s1 && !advance_s1);
	assign in_accept  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			char_s1   <= char_up;
			zero_s1   <= (char_byte == 8'h00);
			row_ok_s1 <= row_ok;
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: seed update, or emit and reload on a terminator
	// ---------------------------------------------------------------------
	msh_pkg::seed_ctl_t seed_ctl;
	logic [31:0]        seed_one;

	assign seed_ctl.step   = advance_s1 && !zero_s1;
	assign seed_ctl.reload = advance_s1 && zero_s1;

	msh_seed u_seed (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (seed_ctl),
		.char_up  (char_s1),
		.word     (row_ok_s1 ? rom_word : 32'd0),
		.seed_one (seed_one)
	);

	// result register: decouples the byte side from a stalled consumer
	logic        out_valid_q;
	logic [31:0] hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seed_ctl.reload) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seed_ctl.reload) begin
			hash_q <= seed_one;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_wr.we |-> !in_accept)
		else $error("byte accepted while crypt table is being filled");

	a_out_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(seed_ctl.reload))
		else $error("hash presented without a retired terminator");

	a_reload_seed: assert property (@(posedge clk) disable iff (!arst_n)
		seed_ctl.reload |=> (seed_one == msh_pkg::SEED_ONE_START))
		else $error("seed not reloaded after terminator");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(seed_ctl.reload && out_valid) |-> !out_stall)
		else $error("pending hash overwritten");

endmodule

// ----- verif/mpq_string_hash_checker.sv -----
`timescale 1ns / 100ps

// Scoreboard for mpq_string_hash: tracks the seed pair per accepted byte,
// queues the hash of every finished string, compares on the result channel.
module mpq_string_hash_checker
	import msh_pkg::*;
#(
	parameter logic [7:0] TERMINATOR = 8'h00
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] hash_value,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,
	output int          errors,
	output int          pending
);

	localparam logic [31:0] GEN_SEED    = 32'h00100001;
	localparam logic [31:0] GEN_MOD     = 32'h002AAAAB;
	localparam logic [7:0]  LOWER_A     = 8'h61;
	localparam logic [7:0]  LOWER_Z     = 8'h7A;
	localparam logic [7:0]  CASE_OFFSET = 8'h20;

	logic [31:0] crypt_word [ROM_DEPTH];
	logic [31:0] run_seed1;
	logic [31:0] run_seed2;
	logic [2:0]  row_sel;
	logic [31:0] hashes_due [$];
	int          fail_tally;

	function automatic logic [31:0] gen_step(input logic [31:0] s);
		return (s * 32'd125 + 32'd3) % GEN_MOD;
	endfunction

	// table is walked column-major, two generator steps per word
	initial begin : build_table
		logic [31:0] s;
		logic [15:0] hi;
		s = GEN_SEED;
		for (int col = 0; col < ROM_COLS; col++) begin
			for (int row = 0; row < ROM_ROWS; row++) begin
				s = gen_step(s);
				hi = s[15:0];
				s = gen_step(s);
				crypt_word[row * ROM_COLS + col] = {hi, s[15:0]};
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : track
		logic [7:0]  c;
		logic [31:0] w;
		logic [31:0] want;
		if (!arst_n) begin
			run_seed1 = SEED_ONE_START;
			run_seed2 = SEED_TWO_START;
			row_sel = '0;
			hashes_due.delete();
			fail_tally = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				row_sel = cfg_wr_data;
			end
			if (out_valid && !out_stall) begin
				if (hashes_due.size() == 0) begin
					$error("hash_value: expected none, got %h", hash_value);
					fail_tally++;
				end else begin
					want = hashes_due.pop_front();
					if (hash_value !== want) begin
						$error("hash_value: expected %h, got %h", want, hash_value);
						fail_tally++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (char_byte == TERMINATOR) begin
					hashes_due.push_back(run_seed1);
					run_seed1 = SEED_ONE_START;
					run_seed2 = SEED_TWO_START;
				end else begin
					c = char_byte;
					if (c >= LOWER_A && c <= LOWER_Z) begin
						c = c - CASE_OFFSET;
					end
					// rows past the last hash type read as zero
					w = (int'(row_sel) < NUM_HASH_TYPES) ?
						crypt_word[int'(row_sel) * ROM_COLS + int'(c)] : 32'd0;
					run_seed1 = w ^ (run_seed1 + run_seed2);
					run_seed2 = 32'(c) + run_seed1 + run_seed2 + (run_seed2 << 5) + 32'd3;
				end
			end
			errors <= fail_tally;
			pending <= hashes_due.size();
		end
	end

endmodule

// ----- verif/mpq_string_hash_tb.sv -----
`timescale 1ns / 100ps

// Top of the mpq_string_hash bench.
// Feeds byte strings into the hash block, each string closed by a zero byte,
// under a sequence of hash_type settings (every row plus the out-of-range ones).
// All prediction and comparison lives in the checker; this module only makes
// stimulus, applies back-pressure on the result side and calls the verdict.
module mpq_string_hash_tb;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 4;
	// leave margin after the last hash before touching config
	localparam int SETTLE_CYCLES   = 8;
	// covers the table fill after reset with plenty to spare
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int IDLE_PERCENT    = 26;
	// phase that runs with no idling on either side
	localparam int QUIET_PHASE     = 3;

	localparam logic [7:0] END_OF_STRING = 8'h00;
	localparam logic [7:0] LOWER_A       = 8'h61;
	localparam logic [7:0] LOWER_Z       = 8'h7A;
	localparam logic [7:0] UPPER_A       = 8'h41;
	localparam logic [7:0] UPPER_Z       = 8'h5A;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  char_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [31:0] hash_value;
	logic        cfg_wr_en   = 1'b0;
	logic [2:0]  cfg_wr_data = 3'd0;

	int   checker_errors;
	int   hashes_pending;
	int   items_sent = 0;
	logic quiet      = 1'b0;

	// Directed strings, run under the reset hash_type:
	//   empty string, "a" vs "A" (case folding must give the same hash),
	//   both ends of the letter range, the neighbors just outside it,
	//   byte extremes and values above 0x7F, back-to-back terminators,
	//   and high bytes whose low 7 bits look like letters (no folding there).
	logic [7:0] directed_bytes [$] = '{
		END_OF_STRING,
		8'h61, END_OF_STRING,
		8'h41, END_OF_STRING,
		8'h7A, 8'h5A, END_OF_STRING,
		8'h60, 8'h7B, 8'h40, 8'h5B, END_OF_STRING,
		8'hFF, 8'h80, 8'h7F, 8'h01, END_OF_STRING,
		END_OF_STRING,
		8'hE1, 8'hFA, END_OF_STRING
	};

	// hash_type per random phase; 5..7 select the all-zero rows
	logic [2:0] phase_hash_type [$] = '{3'd4, 3'd7, 3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd6};

	wire in_fire  = in_valid && !in_stall;
	wire out_fire = out_valid && !out_stall;

	always #HALF_PERIOD clk = ~clk;

	mpq_string_hash dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_byte   (char_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hash_value  (hash_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	mpq_string_hash_checker #(
		.TERMINATOR (END_OF_STRING)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_byte   (char_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hash_value  (hash_value),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (checker_errors),
		.pending     (hashes_pending)
	);

	// Result side back-pressure: random stall each cycle, none in the quiet phase.
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
	end

	// One byte transaction. Random idle cycles go in front; valid is only
	// dropped in a step where it will not be raised again.
	task automatic send_char(input logic [7:0] b);
		while (!quiet && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Mostly short strings, the odd long one; letters of both cases weighted up
	// so the case folding sees plenty of traffic, the rest any nonzero byte.
	task automatic send_random_string();
		int         len;
		logic [7:0] c;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: begin
					c = 8'($urandom_range(LOWER_A, LOWER_Z));
				end
				1: begin
					c = 8'($urandom_range(UPPER_A, UPPER_Z));
				end
				default: begin
					c = 8'($urandom_range(1, 255));
				end
			endcase
			send_char(c);
		end
		send_char(END_OF_STRING);
	endtask

	// Wait until every finished string has produced its hash. The do-while
	// skips the current step so a push at this edge is already visible.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (hashes_pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Main sequence: reset, directed strings, then random phases with a
	// config write in between each (block is idle at that point).
	initial begin
		int phase_end;
		phase_hash_type.push_back(3'($urandom_range(0, 7)));
		phase_hash_type.push_back(3'($urandom_range(0, 7)));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_bytes[i]) begin
			send_char(directed_bytes[i]);
		end
		drain();

		foreach (phase_hash_type[p]) begin
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= phase_hash_type[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			quiet <= (p == QUIET_PHASE);
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				send_random_string();
			end
			drain();
		end

		if (checker_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog: too many cycles with no transaction on either channel.
	initial begin
		int stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (in_fire || out_fire) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- mpq_string_hash.f -----
rtl/msh_pkg.sv
rtl/msh_ram.sv
rtl/msh_fill.sv
rtl/msh_seed.sv
rtl/mpq_string_hash.sv
verif/mpq_string_hash_checker.sv
verif/mpq_string_hash_tb.sv
